@@ hdl/assert_macros.svh @@
// assertion macros shared by the decoder modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, held off while reset is low
`define QSPD_ASSERT(name, clock, resetn, prop, msg) \
    name: assert property (@(posedge clock) disable iff (!resetn) prop) \
        else $error(msg);

// same-cycle implication
`define QSPD_ASSERT_IMPLY(name, clock, resetn, ante, cons, msg) \
    `QSPD_ASSERT(name, clock, resetn, (ante) |-> (cons), msg)

// next-cycle implication
`define QSPD_ASSERT_NEXT(name, clock, resetn, ante, cons, msg) \
    `QSPD_ASSERT(name, clock, resetn, (ante) |=> (cons), msg)

`endif

@@ hdl/qspd_pkg.sv @@
// shared constants, types and helpers of the query string decoder
package qspd_pkg;

    // default sizes
    localparam int PAIR_LIMIT_DEF  = 32;
    localparam int ARENA_LIMIT_DEF = 1024;
    localparam int QUEUE_DEPTH_DEF = 4;

    // special characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_DIG0  = 8'h30;
    localparam logic [7:0] CH_DIG9  = 8'h39;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_F  = 8'h46;
    localparam logic [3:0] HEX_TEN  = 4'd10;

    // result kinds
    localparam logic [2:0] KIND_KEY_BYTE  = 3'd0;
    localparam logic [2:0] KIND_VAL_BYTE  = 3'd1;
    localparam logic [2:0] KIND_KEY_END   = 3'd2;
    localparam logic [2:0] KIND_VAL_END   = 3'd3;
    localparam logic [2:0] KIND_FINISHED  = 3'd4;

    // configuration register indexes and reset values
    localparam logic       CFG_MAX_PAIRS   = 1'b0;
    localparam logic       CFG_BYTE_BUDGET = 1'b1;
    localparam logic [5:0]  MAX_PAIRS_RST   = 6'd32;
    localparam logic [10:0] BYTE_BUDGET_RST = 11'd1024;

    // result slots of one bundle, in emission order
    localparam int NSLOT = 5;
    localparam logic [NSLOT-1:0] SLOT_PCT  = 5'b00001;
    localparam logic [NSLOT-1:0] SLOT_HELD = 5'b00010;
    localparam logic [NSLOT-1:0] SLOT_MID  = 5'b00100;
    localparam logic [NSLOT-1:0] SLOT_VEND = 5'b01000;
    localparam logic [NSLOT-1:0] SLOT_FIN  = 5'b10000;

    typedef enum logic [2:0] {
        PH_START = 3'b001,
        PH_KEY   = 3'b010,
        PH_VALUE = 3'b100
    } phase_t;

    typedef enum logic [2:0] {
        ESC_IDLE  = 3'b001,
        ESC_PCT   = 3'b010,
        ESC_DIGIT = 3'b100
    } esc_t;

    // all results caused by one input byte
    typedef struct packed {
        logic [NSLOT-1:0] mask;       // slots that produce a result
        logic [7:0]       held_byte;  // held hex digit, literal
        logic [7:0]       mid_byte;   // decoded byte of the middle slot
        logic             mid_end;    // middle slot is a key end
        logic             is_value;   // data bytes belong to the value
        logic [4:0]       pair_index;
        logic [5:0]       pair_total;
        logic             failed;
    } qspd_bundle_t;

    // {valid, nibble} of a hex digit character
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= CH_DIG0 && c <= CH_DIG9)
            r = {1'b1, 4'(c - CH_DIG0)};
        else if (c >= CH_LC_A && c <= CH_LC_F)
            r = {1'b1, 4'(c - CH_LC_A) + HEX_TEN};
        else if (c >= CH_UC_A && c <= CH_UC_F)
            r = {1'b1, 4'(c - CH_UC_A) + HEX_TEN};
        return r;
    endfunction

endpackage

@@ hdl/query_string_percent_decoder.sv @@
// Query string percent decoder, top level.
// Bytes of a query string enter on the push/full queue port, one per beat;
// byte 0 ends the string and brings the parser back to string start.
// Decoded key and value bytes, key and value end marks and one finish beat
// per string leave on the empty/pop queue port, oldest first.
// Configuration: cfg_index 0 is max_pairs, 1 is byte_budget; writes are
// taken whenever cfg_valid is high (cfg_ready is tied high) and are meant
// to happen while no string is in progress.
// Throughput: one byte per cycle while each byte gives at most one result
// and the receiver keeps popping; a byte that gives more results (up to
// five) sends them out one slot at a time. The pace is set by the result
// back end, which empties one bundle slot per cycle while the receiver
// pops; a four-deep bundle queue lets the front keep taking bytes
// meanwhile.
// Reset clears the queues, puts the parser at string start and sets the
// registers to 32 pairs and a 1024-byte budget.
// When the receiver stops popping, the output register holds, the queue
// fills and full rises; nothing is dropped.
module query_string_percent_decoder #(
    parameter int PAIR_LIMIT  = qspd_pkg::PAIR_LIMIT_DEF,
    parameter int ARENA_LIMIT = qspd_pkg::ARENA_LIMIT_DEF,
    parameter int QUEUE_DEPTH = qspd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  char_byte,
    input  logic        pop,
    output logic        empty,
    output logic [7:0]  out_byte,
    output logic [2:0]  kind,
    output logic [4:0]  pair_index,
    output logic [5:0]  pair_total,
    output logic        failed,
    output logic        last_of_run,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [10:0] cfg_data
);

    qspd_pkg::qspd_bundle_t push_bundle, head_bundle;
    logic take, bundle_push, queue_empty, queue_pop;

    // input beat taken when the queue has room
    assign take      = push && !full;
    assign cfg_ready = 1'b1;

    qspd_front #(
        .PAIR_LIMIT  (PAIR_LIMIT),
        .ARENA_LIMIT (ARENA_LIMIT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .char_byte   (char_byte),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .bundle_push (bundle_push),
        .bundle      (push_bundle)
    );

    qspd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (bundle_push),
        .data_in  (push_bundle),
        .full     (full),
        .pop      (queue_pop),
        .data_out (head_bundle),
        .empty    (queue_empty)
    );

    qspd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .fifo_data   (head_bundle),
        .fifo_empty  (queue_empty),
        .fifo_pop    (queue_pop),
        .pop         (pop),
        .empty       (empty),
        .out_byte    (out_byte),
        .kind        (kind),
        .pair_index  (pair_index),
        .pair_total  (pair_total),
        .failed      (failed),
        .last_of_run (last_of_run)
    );

endmodule

@@ hdl/qspd_front.sv @@
// parser front: classifies each byte, keeps string state, builds result bundles
`include "assert_macros.svh"

module qspd_front #(
    parameter int PAIR_LIMIT  = qspd_pkg::PAIR_LIMIT_DEF,
    parameter int ARENA_LIMIT = qspd_pkg::ARENA_LIMIT_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  take,
    input  logic [7:0]            char_byte,
    input  logic                  cfg_write,
    input  logic                  cfg_index,
    input  logic [10:0]           cfg_data,
    output logic                  bundle_push,
    output qspd_pkg::qspd_bundle_t bundle
);

    localparam int PCW  = $clog2(PAIR_LIMIT + 1);
    localparam int LW   = (PCW > 6) ? PCW : 6;
    localparam int UW   = $clog2(ARENA_LIMIT);
    localparam int ABW  = $clog2(ARENA_LIMIT + 1);
    localparam int BW   = (ABW > 11) ? ABW : 11;

    logic [5:0]       max_pairs_reg;
    logic [10:0]      byte_budget_reg;
    qspd_pkg::phase_t phase_reg, phase_next;
    qspd_pkg::esc_t   esc_reg, esc_next;
    logic             open_reg, open_next;
    logic [7:0]       held_reg, held_next;
    logic [PCW-1:0]   pair_cnt_reg, pair_cnt_next;
    logic [UW-1:0]    bytes_used_reg, bytes_used_next;
    logic             error_reg, error_next;

    logic [4:0]       hex_c, hex_h;
    logic             is_nul, is_key, do_close, pair_fail, fin, over;
    logic [3:0]       cand, grant;
    logic [2:0]       cnt [4];
    logic [2:0]       room_sat, ntake;
    logic [7:0]       mid_byte;
    logic             mid_end;
    logic [LW-1:0]    limit_eff, pc_ext, pc_after;
    logic [BW-1:0]    budget_eff, bu1, room_wide;

    // effective limits and remaining room in the byte budget
    always_comb
    begin
        limit_eff  = (LW'(max_pairs_reg) < LW'(PAIR_LIMIT)) ? LW'(max_pairs_reg)
                                                            : LW'(PAIR_LIMIT);
        budget_eff = (BW'(byte_budget_reg) < BW'(ARENA_LIMIT)) ? BW'(byte_budget_reg)
                                                                : BW'(ARENA_LIMIT);
        bu1        = BW'(bytes_used_reg) + BW'(1);
        room_wide  = budget_eff - bu1;
        if (budget_eff <= bu1)
            room_sat = 3'd0;
        else if (room_wide >= BW'(4))
            room_sat = 3'd4;
        else
            room_sat = room_wide[2:0];
    end

    // classify the byte and choose the results it asks for
    always_comb
    begin
        hex_c      = qspd_pkg::hex_decode(char_byte);
        hex_h      = qspd_pkg::hex_decode(held_reg);
        is_nul     = (char_byte == qspd_pkg::CH_NUL);
        is_key     = (phase_reg != qspd_pkg::PH_VALUE);
        cand       = 4'b0000;
        mid_byte   = char_byte;
        mid_end    = 1'b0;
        do_close   = 1'b0;
        pair_fail  = 1'b0;
        fin        = 1'b0;
        phase_next = phase_reg;
        open_next  = open_reg;
        esc_next   = esc_reg;
        held_next  = held_reg;

        if (is_nul)
        begin
            fin      = 1'b1;
            do_close = !error_reg && open_reg;
        end
        else if (!error_reg)
        begin
            if (phase_reg == qspd_pkg::PH_START)
                phase_next = qspd_pkg::PH_KEY;
            priority if (phase_reg == qspd_pkg::PH_START && char_byte == qspd_pkg::CH_QMARK)
            begin
                // leading question mark dropped
                cand = 4'b0000;
            end
            else if (char_byte == qspd_pkg::CH_AMP)
            begin
                do_close = open_reg;
            end
            else if (!open_reg && pc_ext >= limit_eff)
            begin
                pair_fail = 1'b1;
            end
            else
            begin
                open_next = 1'b1;
                priority if (is_key && char_byte == qspd_pkg::CH_EQ)
                begin
                    // key ends, pending escape goes out literally
                    cand[0]    = (esc_reg != qspd_pkg::ESC_IDLE);
                    cand[1]    = (esc_reg == qspd_pkg::ESC_DIGIT);
                    cand[2]    = 1'b1;
                    mid_end    = 1'b1;
                    esc_next   = qspd_pkg::ESC_IDLE;
                    phase_next = qspd_pkg::PH_VALUE;
                end
                else if (esc_reg == qspd_pkg::ESC_PCT && hex_c[4])
                begin
                    held_next = char_byte;
                    esc_next  = qspd_pkg::ESC_DIGIT;
                end
                else if (esc_reg == qspd_pkg::ESC_DIGIT && hex_c[4])
                begin
                    cand[2]  = 1'b1;
                    mid_byte = {hex_h[3:0], hex_c[3:0]};
                    esc_next = qspd_pkg::ESC_IDLE;
                end
                else
                begin
                    // malformed or no escape: flush, then decode afresh
                    cand[0] = (esc_reg != qspd_pkg::ESC_IDLE);
                    cand[1] = (esc_reg == qspd_pkg::ESC_DIGIT);
                    if (char_byte == qspd_pkg::CH_PCT)
                    begin
                        esc_next = qspd_pkg::ESC_PCT;
                    end
                    else
                    begin
                        esc_next = qspd_pkg::ESC_IDLE;
                        cand[2]  = 1'b1;
                        mid_byte = (char_byte == qspd_pkg::CH_PLUS) ? qspd_pkg::CH_SPACE
                                                                    : char_byte;
                    end
                end
            end
        end

        // segment close: flush, key end if still in key, value end
        if (do_close)
        begin
            cand[0]    = (esc_reg != qspd_pkg::ESC_IDLE);
            cand[1]    = (esc_reg == qspd_pkg::ESC_DIGIT);
            cand[2]    = is_key;
            cand[3]    = 1'b1;
            mid_end    = 1'b1;
            esc_next   = qspd_pkg::ESC_IDLE;
            open_next  = 1'b0;
            phase_next = qspd_pkg::PH_KEY;
        end
    end

    // budget grant: the first room_sat candidates go out, the rest fail
    always_comb
    begin
        cnt[0] = {2'b00, cand[0]};
        for (int i = 1; i < 4; i++)
            cnt[i] = cnt[i-1] + {2'b00, cand[i]};
        for (int i = 0; i < 4; i++)
            grant[i] = cand[i] && (cnt[i] <= room_sat);
        over  = (cnt[3] > room_sat);
        ntake = over ? room_sat : cnt[3];
    end

    // counters after this byte
    always_comb
    begin
        pc_ext          = LW'(pair_cnt_reg);
        pc_after        = pc_ext + LW'(do_close && !over);
        pair_cnt_next   = pc_after[PCW-1:0];
        bytes_used_next = bytes_used_reg + UW'(ntake);
        error_next      = error_reg || pair_fail || over;
    end

    // bundle toward the back
    always_comb
    begin
        bundle.mask       = {fin, grant};
        bundle.held_byte  = held_reg;
        bundle.mid_byte   = mid_byte;
        bundle.mid_end    = mid_end;
        bundle.is_value   = (phase_reg == qspd_pkg::PH_VALUE);
        bundle.pair_index = pc_ext[4:0];
        bundle.failed     = error_next;
        bundle.pair_total = error_next ? 6'd0 : pc_after[5:0];
        bundle_push       = take && (bundle.mask != '0);
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_pairs_reg   <= qspd_pkg::MAX_PAIRS_RST;
            byte_budget_reg <= qspd_pkg::BYTE_BUDGET_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                qspd_pkg::CFG_MAX_PAIRS:   max_pairs_reg   <= cfg_data[5:0];
                qspd_pkg::CFG_BYTE_BUDGET: byte_budget_reg <= cfg_data;
                default:                   max_pairs_reg   <= max_pairs_reg;
            endcase
        end
    end

    // string state, back to string start on the end byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= qspd_pkg::PH_START;
            esc_reg        <= qspd_pkg::ESC_IDLE;
            open_reg       <= 1'b0;
            held_reg       <= 8'd0;
            pair_cnt_reg   <= '0;
            bytes_used_reg <= '0;
            error_reg      <= 1'b0;
        end
        else if (take)
        begin
            if (is_nul)
            begin
                phase_reg      <= qspd_pkg::PH_START;
                esc_reg        <= qspd_pkg::ESC_IDLE;
                open_reg       <= 1'b0;
                held_reg       <= 8'd0;
                pair_cnt_reg   <= '0;
                bytes_used_reg <= '0;
                error_reg      <= 1'b0;
            end
            else
            begin
                phase_reg      <= phase_next;
                esc_reg        <= esc_next;
                open_reg       <= open_next;
                held_reg       <= held_next;
                pair_cnt_reg   <= pair_cnt_next;
                bytes_used_reg <= bytes_used_next;
                error_reg      <= error_next;
            end
        end
    end

    `QSPD_ASSERT(a_pair_cnt_bound, clk, rst_n, LW'(pair_cnt_reg) <= LW'(PAIR_LIMIT), "pair counter beyond limit")
    `QSPD_ASSERT_NEXT(a_end_clears, clk, rst_n, take && (char_byte == qspd_pkg::CH_NUL), (bytes_used_reg == '0) && !error_reg && (pair_cnt_reg == '0), "end byte did not clear state")

endmodule

@@ hdl/qspd_fifo.sv @@
// bundle queue between parser front and result back
`include "assert_macros.svh"

module qspd_fifo #(
    parameter int DEPTH = qspd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  qspd_pkg::qspd_bundle_t data_in,
    output logic                   full,
    input  logic                   pop,
    output qspd_pkg::qspd_bundle_t data_out,
    output logic                   empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    qspd_pkg::qspd_bundle_t entry_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    // status and head
    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign data_out = entry_reg[rd_ptr_reg];

    // pointer wrap and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        count_next = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= data_in;
    end

    `QSPD_ASSERT_IMPLY(a_no_overflow, clk, rst_n, push, !full || pop, "push into full queue")
    `QSPD_ASSERT_IMPLY(a_no_underflow, clk, rst_n, pop, !empty, "pop from empty queue")

endmodule

@@ hdl/qspd_back.sv @@
// result back: walks each bundle slot by slot into the output register
`include "assert_macros.svh"

module qspd_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  qspd_pkg::qspd_bundle_t fifo_data,
    input  logic                   fifo_empty,
    output logic                   fifo_pop,
    input  logic                   pop,
    output logic                   empty,
    output logic [7:0]             out_byte,
    output logic [2:0]             kind,
    output logic [4:0]             pair_index,
    output logic [5:0]             pair_total,
    output logic                   failed,
    output logic                   last_of_run
);

    qspd_pkg::qspd_bundle_t   cur_reg;
    logic [qspd_pkg::NSLOT-1:0] rem_reg, rem_next, rem_after, sel;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg, byte_next;
    logic [2:0] kind_reg, kind_next;
    logic [4:0] index_reg, index_next;
    logic [5:0] total_reg, total_next;
    logic       failed_reg, failed_next;
    logic       last_reg;
    logic       advance, emit;
    logic [2:0] data_kind;

    // slot selection and bundle refill
    always_comb
    begin
        advance   = !out_valid_reg || pop;
        sel       = rem_reg & (~rem_reg + qspd_pkg::NSLOT'(1));
        emit      = advance && (rem_reg != '0);
        rem_after = emit ? (rem_reg & ~sel) : rem_reg;
        fifo_pop  = !fifo_empty && (rem_after == '0);
        rem_next  = fifo_pop ? fifo_data.mask : rem_after;
    end

    // fields of the selected slot
    always_comb
    begin
        data_kind   = cur_reg.is_value ? qspd_pkg::KIND_VAL_BYTE : qspd_pkg::KIND_KEY_BYTE;
        byte_next   = 8'd0;
        kind_next   = data_kind;
        index_next  = cur_reg.pair_index;
        total_next  = 6'd0;
        failed_next = 1'b0;
        unique case (sel)
            qspd_pkg::SLOT_PCT:  byte_next = qspd_pkg::CH_PCT;
            qspd_pkg::SLOT_HELD: byte_next = cur_reg.held_byte;
            qspd_pkg::SLOT_MID:
            begin
                if (cur_reg.mid_end)
                    kind_next = qspd_pkg::KIND_KEY_END;
                else
                    byte_next = cur_reg.mid_byte;
            end
            qspd_pkg::SLOT_VEND: kind_next = qspd_pkg::KIND_VAL_END;
            qspd_pkg::SLOT_FIN:
            begin
                kind_next   = qspd_pkg::KIND_FINISHED;
                index_next  = 5'd0;
                total_next  = cur_reg.pair_total;
                failed_next = cur_reg.failed;
            end
            default:             byte_next = 8'd0;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rem_reg <= rem_next;
            if (advance)
                out_valid_reg <= emit;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (fifo_pop)
            cur_reg <= fifo_data;
        if (emit)
        begin
            out_byte_reg <= byte_next;
            kind_reg     <= kind_next;
            index_reg    <= index_next;
            total_reg    <= total_next;
            failed_reg   <= failed_next;
            last_reg     <= (rem_after == '0);
        end
    end

    assign empty       = !out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign kind        = kind_reg;
    assign pair_index  = index_reg;
    assign pair_total  = total_reg;
    assign failed      = failed_reg;
    assign last_of_run = last_reg;

    `QSPD_ASSERT_IMPLY(a_bundle_not_void, clk, rst_n, fifo_pop, fifo_data.mask != '0, "empty bundle in queue")

endmodule
